/* rtl/rcpwm_pkg.sv */
// Shared types, constants and register codes for the RC PWM capture unit.
`default_nettype none
package rcpwm_pkg;

	localparam int CHANNELS_DEF = 6;
	localparam int MAX_CH       = 8;
	localparam int PIN_W        = 6;
	localparam int TIME_W       = 16;
	localparam int VAL_W        = 12;
	localparam int CHAN_W       = 3;
	localparam int HISTORY      = 4;
	localparam int HIST_W       = $clog2(HISTORY);
	localparam int SUM_W        = VAL_W + HIST_W;
	localparam int DEADBAND     = 3;
	localparam int PULL         = 2;
	localparam int CFG_IDX_W    = 1;

	localparam logic [VAL_W-1:0] MIN_RESET = 12'd1000;
	localparam logic [VAL_W-1:0] MAX_RESET = 12'd2000;

	localparam logic [CFG_IDX_W-1:0] REG_MIN_PULSE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MAX_PULSE = 1'd1;

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_UPDATE = 1'b1;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SAMPLE,
		ST_SUM,
		ST_EMIT
	} state_t;

	// Step strobes from the sequencer to the datapath
	typedef struct packed {
		logic              accept;
		logic              samp;
		logic              sum;
		logic              emit;
		logic              last;
		logic [CHAN_W-1:0] ch;
	} ctrl_t;

endpackage
`default_nettype wire

/* rtl/rcpwm_if.sv */
// Handshake channel interfaces: pin/update items, channel results, register writes.
`default_nettype none
interface rcpwm_item_if;
	logic                         valid;
	logic                         ready;
	logic                         op;
	logic [rcpwm_pkg::PIN_W-1:0]  pin_levels;
	logic [rcpwm_pkg::TIME_W-1:0] time_us;
	modport source (output valid, op, pin_levels, time_us, input ready);
	modport sink   (input valid, op, pin_levels, time_us, output ready);
endinterface

interface rcpwm_result_if;
	logic                         valid;
	logic                         ready;
	logic [rcpwm_pkg::CHAN_W-1:0] channel;
	logic [rcpwm_pkg::VAL_W-1:0]  value;
	logic                         last;
	modport source (output valid, channel, value, last, input ready);
	modport sink   (input valid, channel, value, last, output ready);
endinterface

interface rcpwm_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [rcpwm_pkg::CFG_IDX_W-1:0] index;
	logic [rcpwm_pkg::VAL_W-1:0]     data;
	modport source (output valid, index, data, input ready);
	modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

/* rtl/rcpwm_ctrl.sv */
// Sequencer that walks the channels through the shared step unit.
`default_nettype none
module rcpwm_ctrl #(
	parameter int CHANNELS = rcpwm_pkg::CHANNELS_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             in_valid,
	input  wire logic             in_op,
	input  wire logic             out_free,
	output logic                  in_ready,
	output rcpwm_pkg::ctrl_t      ctrl
);

	localparam logic [rcpwm_pkg::CHAN_W-1:0] LAST_CH = rcpwm_pkg::CHAN_W'(CHANNELS - 1);

	rcpwm_pkg::state_t                state_q, state_d;
	logic [rcpwm_pkg::CHAN_W-1:0]     ch_q, ch_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcpwm_pkg::ST_IDLE;
			ch_q    <= '0;
		end else begin
			state_q <= state_d;
			ch_q    <= ch_d;
		end
	end

	always_comb begin
		state_d     = state_q;
		ch_d        = ch_q;
		in_ready    = 1'b0;
		ctrl.accept = 1'b0;
		ctrl.samp   = 1'b0;
		ctrl.sum    = 1'b0;
		ctrl.emit   = 1'b0;
		ctrl.last   = (ch_q == LAST_CH);
		ctrl.ch     = ch_q;
		unique case (state_q)
			rcpwm_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					ctrl.accept = 1'b1;
					ch_d        = '0;
					state_d     = (in_op == rcpwm_pkg::OP_UPDATE) ? rcpwm_pkg::ST_SUM
					                                              : rcpwm_pkg::ST_SAMPLE;
				end
			end
			rcpwm_pkg::ST_SAMPLE: begin
				ctrl.samp = 1'b1;
				if (ch_q == LAST_CH) begin
					state_d = rcpwm_pkg::ST_IDLE;
				end else begin
					ch_d = ch_q + 1'b1;
				end
			end
			rcpwm_pkg::ST_SUM: begin
				ctrl.sum = 1'b1;
				state_d  = rcpwm_pkg::ST_EMIT;
			end
			rcpwm_pkg::ST_EMIT: begin
				// hold until the result register can take the beat
				if (out_free) begin
					ctrl.emit = 1'b1;
					if (ch_q == LAST_CH) begin
						state_d = rcpwm_pkg::ST_IDLE;
					end else begin
						ch_d    = ch_q + 1'b1;
						state_d = rcpwm_pkg::ST_SUM;
					end
				end
			end
			default: state_d = rcpwm_pkg::ST_IDLE;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/rcpwm_datapath.sv */
// Channel state storage, shared capture/smoothing step unit and result register.
`default_nettype none
module rcpwm_datapath #(
	parameter int CHANNELS = rcpwm_pkg::CHANNELS_DEF
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire rcpwm_pkg::ctrl_t                  ctrl,
	input  wire logic                              op,
	input  wire logic [rcpwm_pkg::PIN_W-1:0]       pin_levels,
	input  wire logic [rcpwm_pkg::TIME_W-1:0]      time_us,
	input  wire logic                              cfg_we,
	input  wire logic [rcpwm_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [rcpwm_pkg::VAL_W-1:0]       cfg_data,
	input  wire logic                              res_ready,
	output logic                                   res_valid,
	output logic [rcpwm_pkg::CHAN_W-1:0]           res_channel,
	output logic [rcpwm_pkg::VAL_W-1:0]            res_value,
	output logic                                   res_last,
	output logic                                   out_free
);

	localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int VW    = rcpwm_pkg::VAL_W;
	localparam int TW    = rcpwm_pkg::TIME_W;
	localparam int SW    = rcpwm_pkg::SUM_W;
	localparam int HW    = rcpwm_pkg::HIST_W;

	logic [CH_W-1:0]          ch_i;
	logic [rcpwm_pkg::MAX_CH-1:0] pins_wide;
	logic [CHANNELS-1:0]      pins_m;

	logic [CHANNELS-1:0]      prev_q;
	logic [CHANNELS-1:0]      chg_q;
	logic [CHANNELS-1:0]      pins_q;
	logic [TW-1:0]            time_q;
	logic [VW-1:0]            min_q, max_q;
	logic [HW-1:0]            rp_q;
	logic [TW-1:0]            rise_q   [CHANNELS];
	logic [VW-1:0]            cap_q    [CHANNELS];
	logic [VW-1:0]            hist_q   [CHANNELS][rcpwm_pkg::HISTORY];
	logic [SW-1:0]            sum_q    [CHANNELS];
	logic [VW-1:0]            smooth_q [CHANNELS];
	logic [VW-1:0]            mean_q;
	logic                     out_valid_q;

	logic [TW-1:0]            width_d;
	logic                     width_ok;
	logic [SW-1:0]            sum_new;
	logic [SW-1:0]            sum_rnd;
	logic [VW:0]              mean_x, sv_x, sv_db;
	logic [VW-1:0]            sv_new;

	assign ch_i      = ctrl.ch[CH_W-1:0];
	assign pins_wide = rcpwm_pkg::MAX_CH'(pin_levels);
	assign pins_m    = pins_wide[CHANNELS-1:0];

	// Falling edge: wrapped width since the rise, accepted only strictly inside the window
	assign width_d  = time_q - rise_q[ch_i];
	assign width_ok = (TW'(min_q) < width_d) && (width_d < TW'(max_q));

	// Running sum: drop the entry being overwritten, add the new capture
	assign sum_new = sum_q[ch_i] - SW'(hist_q[ch_i][rp_q]) + SW'(cap_q[ch_i]);
	assign sum_rnd = sum_new + SW'(rcpwm_pkg::HISTORY / 2);

	assign mean_x = {1'b0, mean_q};
	assign sv_x   = {1'b0, smooth_q[ch_i]};

	always_comb begin
		priority if (mean_x + (VW+1)'(rcpwm_pkg::DEADBAND) < sv_x) begin
			sv_db = mean_x + (VW+1)'(rcpwm_pkg::PULL);
		end else if (mean_x > sv_x + (VW+1)'(rcpwm_pkg::DEADBAND)) begin
			sv_db = mean_x - (VW+1)'(rcpwm_pkg::PULL);
		end else begin
			sv_db = sv_x;
		end
		priority if (sv_db < {1'b0, min_q}) begin
			sv_new = min_q;
		end else if (sv_db > {1'b0, max_q}) begin
			sv_new = max_q;
		end else begin
			sv_new = sv_db[VW-1:0];
		end
	end

	assign out_free = !out_valid_q || res_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q       <= rcpwm_pkg::MIN_RESET;
			max_q       <= rcpwm_pkg::MAX_RESET;
			prev_q      <= '0;
			rp_q        <= '0;
			out_valid_q <= 1'b0;
			for (int c = 0; c < CHANNELS; c++) begin
				rise_q[c]   <= '0;
				cap_q[c]    <= '0;
				sum_q[c]    <= '0;
				smooth_q[c] <= '0;
				for (int h = 0; h < rcpwm_pkg::HISTORY; h++) begin
					hist_q[c][h] <= '0;
				end
			end
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rcpwm_pkg::REG_MIN_PULSE: min_q <= cfg_data;
					rcpwm_pkg::REG_MAX_PULSE: max_q <= cfg_data;
					default: ;
				endcase
			end
			if (ctrl.accept) begin
				if (op == rcpwm_pkg::OP_UPDATE) begin
					rp_q <= rp_q + 1'b1;
				end else begin
					prev_q <= pins_m;
				end
			end
			if (ctrl.samp && chg_q[ch_i]) begin
				if (pins_q[ch_i]) begin
					rise_q[ch_i] <= time_q;
				end else if (width_ok) begin
					cap_q[ch_i] <= width_d[VW-1:0];
				end
			end
			if (ctrl.sum) begin
				hist_q[ch_i][rp_q] <= cap_q[ch_i];
				sum_q[ch_i]        <= sum_new;
			end
			if (ctrl.emit) begin
				smooth_q[ch_i] <= sv_new;
				out_valid_q    <= 1'b1;
			end else if (res_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Item and result payload, no reset needed
	always_ff @(posedge clk) begin
		if (ctrl.accept && op == rcpwm_pkg::OP_SAMPLE) begin
			chg_q  <= pins_m ^ prev_q;
			pins_q <= pins_m;
			time_q <= time_us;
		end
		if (ctrl.sum) begin
			mean_q <= sum_rnd[SW-1:HW];
		end
		if (ctrl.emit) begin
			res_channel <= ctrl.ch;
			res_value   <= sv_new;
			res_last    <= ctrl.last;
		end
	end

	assign res_valid = out_valid_q;

endmodule
`default_nettype wire

/* rtl/rc_pwm_capture_and_smoothing_unit.sv */
// Top level of the RC PWM pulse capture and smoothing unit.
`default_nettype none
// A pin sample item (op 0) checks each channel pin for an edge, one channel per
// cycle: a rise stores the time, a fall keeps the wrapped width when it lies strictly
// between min_pulse_us and max_pulse_us. It gives no result. An update item (op 1)
// advances the four-entry history ring and, per channel, forms the running sum and
// rounded mean, then applies deadband, pull and clamp in a step that waits until
// the result register is free and then loads it: channel 0 first, last set on the
// final channel. The single step unit is shared by all channels under the channel
// sequencer. Registers 0 and 1 hold min and max pulse width.
module rc_pwm_capture_and_smoothing_unit #(
	parameter int CHANNELS = rcpwm_pkg::CHANNELS_DEF
) (
	input wire logic       clk,
	input wire logic       arst_n,
	rcpwm_item_if.sink     item,
	rcpwm_result_if.source result,
	rcpwm_cfg_if.sink      cfg
);

	rcpwm_pkg::ctrl_t ctrl;
	logic             out_free;

	assign cfg.ready = 1'b1;

	rcpwm_ctrl #(
		.CHANNELS (CHANNELS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (item.valid),
		.in_op    (item.op),
		.out_free (out_free),
		.in_ready (item.ready),
		.ctrl     (ctrl)
	);

	rcpwm_datapath #(
		.CHANNELS (CHANNELS)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.ctrl        (ctrl),
		.op          (item.op),
		.pin_levels  (item.pin_levels),
		.time_us     (item.time_us),
		.cfg_we      (cfg.valid && cfg.ready),
		.cfg_index   (cfg.index),
		.cfg_data    (cfg.data),
		.res_ready   (result.ready),
		.res_valid   (result.valid),
		.res_channel (result.channel),
		.res_value   (result.value),
		.res_last    (result.last),
		.out_free    (out_free)
	);

`ifndef SYNTH
	a_idle_no_steps: assert property (@(posedge clk) disable iff (!arst_n)
		item.ready |-> !(ctrl.samp || ctrl.sum || ctrl.emit))
		else $error("step strobe while taking items");

	a_result_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result.valid) |-> $past(ctrl.emit))
		else $error("result appeared without an emit step");

	a_last_returns_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(ctrl.emit && ctrl.last) |=> item.ready)
		else $error("update did not finish after last channel");

	a_sum_then_emit: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.emit |-> !ctrl.sum && !ctrl.samp)
		else $error("overlapping step strobes");
`endif

endmodule
`default_nettype wire
